FILE: src/sib1_pkg.sv
// Package: shared types, constants and tables of the SIB1 PDSCH grant decoder.
package sib1_pkg;

   localparam int MaxBwpRbsDefault = 275;
   localparam int RivWidth = 16;
   localparam int QuotWidth = 16;
   localparam int QueueDepth = 4;

   localparam logic [1:0] StatusOk = 2'd0;
   localparam logic [1:0] StatusNoRow = 2'd1;
   localparam logic [1:0] StatusBadMcs = 2'd2;

   localparam logic [1:0] CsrBwpSize = 2'd0;
   localparam logic [1:0] CsrDmrsPos = 2'd1;
   localparam logic [1:0] CsrMuxPattern = 2'd2;

   localparam logic [4:0] McsMax = 5'd28;

   typedef struct packed {
      logic [1:0] status;
      logic       mapping_type;
      logic       slot_offset;
      logic [3:0] start_symbol;
      logic [3:0] symbol_count;
      logic [1:0] dmrs_extra_position;
      logic [1:0] cdm_groups_no_data;
      logic [9:0] code_rate_x1024;
      logic       vrb_interleaved;
      logic [1:0] redundancy_version_out;
   } class_type;

   // row: valid, mapping, k0, S2, L2, S3, L3
   typedef struct packed {
      logic       valid;
      logic       mapping;
      logic       k0;
      logic [3:0] s2;
      logic [3:0] l2;
      logic [3:0] s3;
      logic [3:0] l3;
   } row_type;

   function automatic row_type r(input int v, input int m, input int k, input int s2,
                                 input int l2, input int s3, input int l3);
      row_type x;
      x.valid = v[0];
      x.mapping = m[0];
      x.k0 = k[0];
      x.s2 = s2[3:0];
      x.l2 = l2[3:0];
      x.s3 = s3[3:0];
      x.l3 = l3[3:0];
      return x;
   endfunction

   function automatic row_type time_row(input logic [1:0] pat, input logic [3:0] idx);
      row_type x;
      x = r(0, 0, 0, 0, 0, 0, 0);
      if (pat == 2'd1) begin
         case (idx)
            4'd0: x = r(1, 0, 0, 2, 12, 3, 11);
            4'd1: x = r(1, 0, 0, 2, 10, 3, 9);
            4'd2: x = r(1, 0, 0, 2, 9, 3, 8);
            4'd3: x = r(1, 0, 0, 2, 7, 3, 6);
            4'd4: x = r(1, 0, 0, 2, 5, 3, 4);
            4'd5: x = r(1, 1, 0, 9, 4, 10, 4);
            4'd6: x = r(1, 1, 0, 4, 4, 6, 4);
            4'd7: x = r(1, 1, 0, 5, 7, 5, 7);
            4'd8: x = r(1, 1, 0, 5, 2, 5, 2);
            4'd9: x = r(1, 1, 0, 9, 2, 9, 2);
            4'd10: x = r(1, 1, 0, 12, 2, 12, 2);
            4'd11: x = r(1, 0, 0, 1, 13, 1, 13);
            4'd12: x = r(1, 0, 0, 1, 6, 1, 6);
            4'd13: x = r(1, 0, 0, 2, 4, 2, 4);
            4'd14: x = r(1, 1, 0, 4, 7, 4, 7);
            default: x = r(1, 1, 0, 8, 4, 8, 4);
         endcase
      end else if (pat == 2'd2) begin
         case (idx)
            4'd0: x = r(1, 1, 0, 2, 2, 2, 2);
            4'd1: x = r(1, 1, 0, 4, 2, 4, 2);
            4'd2: x = r(1, 1, 0, 6, 2, 6, 2);
            4'd3: x = r(1, 1, 0, 8, 2, 8, 2);
            4'd4: x = r(1, 1, 0, 10, 2, 10, 2);
            4'd5: x = r(1, 1, 1, 2, 2, 2, 2);
            4'd6: x = r(1, 1, 1, 4, 2, 4, 2);
            4'd7: x = r(1, 1, 0, 2, 4, 2, 4);
            4'd8: x = r(1, 1, 0, 4, 4, 4, 4);
            4'd9: x = r(1, 1, 0, 6, 4, 6, 4);
            4'd10: x = r(1, 1, 0, 8, 4, 8, 4);
            4'd11: x = r(1, 1, 0, 10, 4, 10, 4);
            4'd12: x = r(1, 1, 0, 2, 7, 2, 7);
            4'd13: x = r(1, 0, 0, 2, 12, 3, 11);
            4'd14: x = r(1, 1, 1, 2, 4, 2, 4);
            default: x = r(0, 0, 0, 0, 0, 0, 0);
         endcase
      end else if (pat == 2'd3) begin
         case (idx)
            4'd0: x = r(1, 1, 0, 2, 2, 2, 2);
            4'd1: x = r(1, 1, 0, 4, 2, 4, 2);
            4'd2: x = r(1, 1, 0, 6, 2, 6, 2);
            4'd3: x = r(1, 1, 0, 8, 2, 8, 2);
            4'd4: x = r(1, 1, 0, 10, 2, 10, 2);
            4'd7: x = r(1, 1, 0, 2, 4, 2, 4);
            4'd8: x = r(1, 1, 0, 4, 4, 4, 4);
            4'd9: x = r(1, 1, 0, 6, 4, 6, 4);
            4'd10: x = r(1, 1, 0, 8, 4, 8, 4);
            4'd11: x = r(1, 1, 0, 10, 4, 10, 4);
            4'd12: x = r(1, 1, 0, 2, 7, 2, 7);
            4'd13: x = r(1, 0, 0, 2, 12, 3, 11);
            4'd14: x = r(1, 0, 0, 0, 6, 0, 6);
            4'd15: x = r(1, 0, 0, 2, 6, 2, 6);
            default: x = r(0, 0, 0, 0, 0, 0, 0);
         endcase
      end
      return x;
   endfunction

   function automatic logic [9:0] code_rate(input logic [4:0] mcs);
      logic [9:0] v;
      unique case (mcs)
         5'd0: v = 10'd120;  5'd1: v = 10'd157;  5'd2: v = 10'd193;  5'd3: v = 10'd251;
         5'd4: v = 10'd308;  5'd5: v = 10'd379;  5'd6: v = 10'd449;  5'd7: v = 10'd526;
         5'd8: v = 10'd602;  5'd9: v = 10'd679;  5'd10: v = 10'd340; 5'd11: v = 10'd378;
         5'd12: v = 10'd434; 5'd13: v = 10'd490; 5'd14: v = 10'd553; 5'd15: v = 10'd616;
         5'd16: v = 10'd658; 5'd17: v = 10'd438; 5'd18: v = 10'd466; 5'd19: v = 10'd517;
         5'd20: v = 10'd567; 5'd21: v = 10'd616; 5'd22: v = 10'd666; 5'd23: v = 10'd719;
         5'd24: v = 10'd772; 5'd25: v = 10'd822; 5'd26: v = 10'd873; 5'd27: v = 10'd910;
         5'd28: v = 10'd948;
         default: v = 10'd0;
      endcase
      return v;
   endfunction

endpackage

FILE: src/sib1_pdsch_grant_decoder.sv
// Top level: SIB1 PDSCH grant decoder.
// Throughput: one grant per cycle while rsp_stall is low;
// the back end divider is 16 stages, one quotient bit each.
// A 4-entry queue decouples the front classifier from the back end.
// Synchronous active-high reset clears valids; registers return to 24, 2, 1.
module sib1_pdsch_grant_decoder import sib1_pkg::*; #(
   parameter int MAX_BWP_RBS = MaxBwpRbsDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [8:0]  csr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [15:0] req_riv,
   input  logic [3:0]  req_time_alloc_index,
   input  logic        req_vrb_to_prb_mapping,
   input  logic [4:0]  req_mcs_index,
   input  logic [1:0]  req_redundancy_version_in,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [8:0]  rsp_rb_start,
   output logic [8:0]  rsp_rb_count,
   output logic        rsp_mapping_type,
   output logic        rsp_slot_offset,
   output logic [3:0]  rsp_start_symbol,
   output logic [3:0]  rsp_symbol_count,
   output logic [1:0]  rsp_dmrs_extra_position,
   output logic [1:0]  rsp_cdm_groups_no_data,
   output logic [9:0]  rsp_code_rate_x1024,
   output logic        rsp_vrb_interleaved,
   output logic [1:0]  rsp_redundancy_version_out
);

   localparam int NW = $clog2(MAX_BWP_RBS + 1);
   localparam int QW = RivWidth + NW + $bits(class_type);

   logic [8:0] bwp_ff;
   logic [1:0] dmrs_ff, mux_ff;

   logic                f_valid, f_stall;
   logic [RivWidth-1:0] f_riv;
   logic [NW-1:0]       f_n;
   class_type           f_cls;
   logic                q_valid, q_stall;
   logic [QW-1:0]       q_data;
   logic [8:0]          start, count;
   class_type           cls;

   always_ff @(posedge clock) begin
      if (reset) begin
         bwp_ff <= 9'd24;
         dmrs_ff <= 2'd2;
         mux_ff <= 2'd1;
      end else if (csr_write) begin
         case (csr_index)
            CsrBwpSize: bwp_ff <= csr_data;
            CsrDmrsPos: dmrs_ff <= csr_data[1:0];
            CsrMuxPattern: mux_ff <= csr_data[1:0];
            default: ;
         endcase
      end
   end

   sib1_front #(.MAX_BWP_RBS(MAX_BWP_RBS)) u_front (
      .clock, .reset,
      .bwp_size(bwp_ff), .dmrs_pos(dmrs_ff), .mux_pattern(mux_ff),
      .in_valid(req_valid), .in_stall(req_stall),
      .in_riv(req_riv), .in_tdra(req_time_alloc_index), .in_vrb(req_vrb_to_prb_mapping),
      .in_mcs(req_mcs_index), .in_rv(req_redundancy_version_in),
      .out_valid(f_valid), .out_stall(f_stall),
      .out_riv(f_riv), .out_n(f_n), .out_cls(f_cls)
   );

   sib1_queue #(.W(QW), .DEPTH(QueueDepth)) u_queue (
      .clock, .reset,
      .in_valid(f_valid), .in_stall(f_stall), .in_data({f_riv, f_n, f_cls}),
      .out_valid(q_valid), .out_stall(q_stall), .out_data(q_data)
   );

   sib1_back #(.MAX_BWP_RBS(MAX_BWP_RBS)) u_back (
      .clock, .reset,
      .in_valid(q_valid), .in_stall(q_stall),
      .in_riv(q_data[QW-1 -: RivWidth]), .in_n(q_data[$bits(class_type) +: NW]),
      .in_cls(class_type'(q_data[$bits(class_type)-1:0])),
      .out_valid(rsp_valid), .out_stall(rsp_stall),
      .out_start(start), .out_count(count), .out_cls(cls)
   );

   assign rsp_status = cls.status;
   assign rsp_rb_start = start;
   assign rsp_rb_count = count;
   assign rsp_mapping_type = cls.mapping_type;
   assign rsp_slot_offset = cls.slot_offset;
   assign rsp_start_symbol = cls.start_symbol;
   assign rsp_symbol_count = cls.symbol_count;
   assign rsp_dmrs_extra_position = cls.dmrs_extra_position;
   assign rsp_cdm_groups_no_data = cls.cdm_groups_no_data;
   assign rsp_code_rate_x1024 = cls.code_rate_x1024;
   assign rsp_vrb_interleaved = cls.vrb_interleaved;
   assign rsp_redundancy_version_out = cls.redundancy_version_out;

endmodule

FILE: src/sib1_front.sv
// Front end: register the grant, clamp the BWP size and classify the time row and MCS.
module sib1_front import sib1_pkg::*; #(
   parameter int MAX_BWP_RBS = MaxBwpRbsDefault,
   localparam int NW = $clog2(MAX_BWP_RBS + 1)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [8:0]          bwp_size,
   input  logic [1:0]          dmrs_pos,
   input  logic [1:0]          mux_pattern,
   input  logic                in_valid,
   output logic                in_stall,
   input  logic [RivWidth-1:0] in_riv,
   input  logic [3:0]          in_tdra,
   input  logic                in_vrb,
   input  logic [4:0]          in_mcs,
   input  logic [1:0]          in_rv,
   output logic                out_valid,
   input  logic                out_stall,
   output logic [RivWidth-1:0] out_riv,
   output logic [NW-1:0]       out_n,
   output class_type           out_cls
);

   logic                valid_ff, valid_in;
   logic [RivWidth-1:0] riv_ff;
   logic [NW-1:0]       n_ff, n_in;
   class_type           cls_ff, cls_in;
   row_type             row;
   logic                row_ok;
   logic [3:0]          sym_l;

   assign in_stall = valid_ff && out_stall;
   assign valid_in = in_valid ? 1'b1 : (valid_ff && out_stall);

   always_comb begin
      if (bwp_size == 9'd0) n_in = NW'(1);
      else if ({1'b0, bwp_size} > 10'(MAX_BWP_RBS)) n_in = NW'(MAX_BWP_RBS);
      else n_in = NW'(bwp_size);
   end

   always_comb begin
      row = time_row(mux_pattern, in_tdra);
      row_ok = row.valid && (dmrs_pos == 2'd2 || dmrs_pos == 2'd3);
      cls_in = '0;
      cls_in.status = StatusOk;
      cls_in.symbol_count = 4'd14;
      if (row_ok) begin
         cls_in.mapping_type = row.mapping;
         cls_in.slot_offset = row.k0;
         cls_in.start_symbol = (dmrs_pos == 2'd2) ? row.s2 : row.s3;
         cls_in.symbol_count = (dmrs_pos == 2'd2) ? row.l2 : row.l3;
      end else begin
         cls_in.status = StatusNoRow;
      end
      sym_l = cls_in.symbol_count;
      cls_in.cdm_groups_no_data = (sym_l == 4'd2) ? 2'd1 : 2'd2;
      if (!cls_in.mapping_type) cls_in.dmrs_extra_position = 2'd2;
      else if (sym_l == 4'd7) cls_in.dmrs_extra_position = 2'd1;
      else cls_in.dmrs_extra_position = 2'd0;
      if (in_mcs <= McsMax) cls_in.code_rate_x1024 = code_rate(in_mcs);
      else if (row_ok) cls_in.status = StatusBadMcs;
      cls_in.vrb_interleaved = in_vrb;
      cls_in.redundancy_version_out = in_rv;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!in_stall) begin
         valid_ff <= valid_in;
      end
      if (!in_stall && in_valid) begin
         riv_ff <= in_riv;
         n_ff <= n_in;
         cls_ff <= cls_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_riv = riv_ff;
   assign out_n = n_ff;
   assign out_cls = cls_ff;

endmodule

FILE: src/sib1_queue.sv
// Short queue between front and back end.
module sib1_queue import sib1_pkg::*; #(
   parameter int W = 8,
   parameter int DEPTH = QueueDepth
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_stall,
   input  logic [W-1:0] in_data,
   output logic         out_valid,
   input  logic         out_stall,
   output logic [W-1:0] out_data
);

   localparam int AW = $clog2(DEPTH);

   logic [W-1:0]  mem [DEPTH];
   logic [AW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [AW:0]   cnt_ff, cnt_in;
   logic          push, pop;

   assign in_stall = (cnt_ff == (AW+1)'(DEPTH));
   assign out_valid = (cnt_ff != '0);
   assign out_data = mem[rd_ff];
   assign push = in_valid && !in_stall;
   assign pop = out_valid && !out_stall;
   assign wr_in = (wr_ff == AW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
   assign rd_in = (rd_ff == AW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
   assign cnt_in = cnt_ff + (AW+1)'(push) - (AW+1)'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_in;
         if (pop) rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) mem[wr_ff] <= in_data;
   end

endmodule

FILE: src/sib1_back.sv
// Back end: pipelined RIV divider, wrap folding and output register.
module sib1_back import sib1_pkg::*; #(
   parameter int MAX_BWP_RBS = MaxBwpRbsDefault,
   localparam int NW = $clog2(MAX_BWP_RBS + 1)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_stall,
   input  logic [RivWidth-1:0] in_riv,
   input  logic [NW-1:0]       in_n,
   input  class_type           in_cls,
   output logic                out_valid,
   input  logic                out_stall,
   output logic [8:0]          out_start,
   output logic [8:0]          out_count,
   output class_type           out_cls
);

   // one quotient bit per stage, restoring division
   localparam int S = RivWidth;

   logic                v_ff [S+1];
   logic [RivWidth-1:0] rem_ff [S+1];
   logic [QuotWidth-1:0] q_ff [S+1];
   logic [NW-1:0]       n_ff [S+1];
   class_type           c_ff [S+1];
   logic                adv;
   logic [RivWidth-1:0] rem_in [S];
   logic [QuotWidth-1:0] q_in [S];

   logic                ov_ff;
   logic [8:0]          st_ff, st_in, ct_ff, ct_in;
   class_type           oc_ff;
   logic [QuotWidth-1:0] a;
   logic [RivWidth-1:0] b;
   logic [NW-1:0]       n;

   assign adv = !(ov_ff && out_stall);
   assign in_stall = !adv;

   always_comb begin
      for (int i = 0; i < S; i++) begin
         logic [RivWidth+NW-1:0] t;
         logic [RivWidth+NW-1:0] d;
         t = {{NW{1'b0}}, rem_ff[i]} >> (S - 1 - i);
         d = {{RivWidth{1'b0}}, n_ff[i]};
         rem_in[i] = rem_ff[i];
         q_in[i] = q_ff[i];
         if (t >= d) begin
            rem_in[i] = rem_ff[i] - RivWidth'(d << (S - 1 - i));
            q_in[i][S-1-i] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= S; i++) v_ff[i] <= 1'b0;
         ov_ff <= 1'b0;
      end else if (adv) begin
         v_ff[0] <= in_valid;
         for (int i = 0; i < S; i++) v_ff[i+1] <= v_ff[i];
         ov_ff <= v_ff[S];
      end
      if (adv) begin
         rem_ff[0] <= in_riv;
         q_ff[0] <= '0;
         n_ff[0] <= in_n;
         c_ff[0] <= in_cls;
         for (int i = 0; i < S; i++) begin
            rem_ff[i+1] <= rem_in[i];
            q_ff[i+1] <= q_in[i];
            n_ff[i+1] <= n_ff[i];
            c_ff[i+1] <= c_ff[i];
         end
         st_ff <= st_in;
         ct_ff <= ct_in;
         oc_ff <= c_ff[S];
      end
   end

   always_comb begin
      a = q_ff[S];
      b = rem_ff[S];
      n = n_ff[S];
      if ({1'b0, a} + 17'd1 <= 17'(n) - 17'(b)) begin
         st_in = 9'(b);
         ct_in = 9'(a + 1'b1);
      end else if (a <= QuotWidth'(n)) begin
         st_in = 9'(n - 1'b1 - NW'(b));
         ct_in = 9'(QuotWidth'(n) - a + 1'b1);
      end else begin
         st_in = '0;
         ct_in = '0;
      end
   end

   assign out_valid = ov_ff;
   assign out_start = st_ff;
   assign out_count = ct_ff;
   assign out_cls = oc_ff;

endmodule

FILE: src/sib1_checker.sv
// Port-level checker for the SIB1 PDSCH grant decoder, bound to the top level.
module sib1_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [1:0] rsp_status,
   input logic [8:0] rsp_rb_count,
   input logic [3:0] rsp_symbol_count,
   input logic [1:0] rsp_cdm_groups_no_data,
   input logic [9:0] rsp_code_rate_x1024
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status))
      else $error("response dropped while stalled");

   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status != 2'd3)
      else $error("bad status");

   a_cdm: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_cdm_groups_no_data == 2'd1) == (rsp_symbol_count == 4'd2))
      else $error("cdm groups mismatch");

   a_rate: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == 2'd2 |-> rsp_code_rate_x1024 == 10'd0)
      else $error("rate on bad mcs");

   a_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_rb_count <= 9'd275)
      else $error("rb count out of range");

endmodule

bind sib1_pdsch_grant_decoder sib1_checker u_sib1_checker (
   .clock, .reset, .rsp_valid, .rsp_stall, .rsp_status, .rsp_rb_count,
   .rsp_symbol_count, .rsp_cdm_groups_no_data, .rsp_code_rate_x1024
);
